// ----- rtl/core/idi_pkg.sv -----
`timescale 1ns / 1ps
package idi_pkg;

    localparam int NUM_W = 128;
    localparam int DEN_W = 72;
    localparam int Q_W   = 64;
    localparam int IT_W  = 8;
    localparam int D2_W  = 50;

    localparam logic [IT_W-1:0] W_ITERS = 8'd63;
    localparam logic [IT_W-1:0] F_ITERS = 8'd128;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_HIT     = 1'b1;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic [31:0] load;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numer;
        logic [DEN_W-1:0] denom;
        logic [IT_W-1:0]  iters;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_SQ,
        S_SUM,
        S_DIVW,
        S_MUL0,
        S_MUL1,
        S_ACC,
        S_DIVF,
        S_OUT
    } t_state;

endpackage

// ----- rtl/core/idi_table.sv -----
`timescale 1ns / 1ps
module idi_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int AW          = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  idi_pkg::t_entry i_wr_data,
    input  logic            i_wr_act,
    input  logic [AW-1:0]   i_rd_addr,
    output idi_pkg::t_entry o_rd_data,
    output logic            o_rd_act
);
    import idi_pkg::*;

    t_entry                 r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_act;
    t_entry                 r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else if (i_wr_en) begin
            r_act[i_wr_addr] <= i_wr_act;
        end
    end

    assign o_rd_data = r_rd;
    assign o_rd_act  = r_act[i_rd_addr];

endmodule

// ----- rtl/core/idi_div.sv -----
`timescale 1ns / 1ps
module idi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  idi_pkg::t_div_req i_req,
    output logic              o_busy,
    output logic              o_done,
    output logic [63:0]       o_quot
);
    import idi_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [IT_W-1:0]  r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_num, n_num;
    logic [Q_W-1:0]   r_q, n_q;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_num   = r_num;
        n_q     = r_q;
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.iters;
            n_rem  = '0;
            n_den  = i_req.denom;
            n_num  = i_req.numer;
            n_q    = '0;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            if (!w_diff[DEN_W]) begin
                n_rem = w_diff[DEN_W-1:0];
                n_q   = {r_q[Q_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DEN_W-1:0];
                n_q   = {r_q[Q_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == IT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_num <= n_num;
        r_q   <= n_q;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("start while busy");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("busy with zero count");

endmodule

// ----- rtl/core/inverse_distance_interpolator_core.sv -----
`timescale 1ns / 1ps
// Inverse-distance (power 2) interpolator over a table of up to MAX_ENTRIES
// sample points held in a synchronous-read RAM. A query beat walks entries
// 0 .. n-1, n being entries_in_use capped at MAX_ENTRIES: an inactive entry
// is skipped; an active one is squared and summed to d2 and, unless it is
// coincident, weighted by the radix-2 divider that forms each weight 2^62/d2
// (63 iterations), then multiplied and accumulated. A query that hits no
// coincident entry and finds an active one ends with a 128-iteration division
// in the same divider. The input stalls for the whole query; the result sits
// in an output register, so a new beat may enter while it waits to be taken.
module inverse_distance_interpolator_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [5:0]         i_index,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic signed [31:0] i_load_in,
    input  logic               i_active_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_value,
    output logic               o_coincident,
    output logic               o_none_active,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import idi_pkg::*;

    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW0 = $clog2(MAX_ENTRIES + 1);
    localparam int CW  = (CW0 > 7) ? CW0 : 7;

    t_state           r_state, n_state;
    logic [6:0]       r_entries;
    logic [15:0]      r_hit;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_n, n_n;
    logic             r_any, n_any;
    logic [23:0]      r_qx, r_qy, r_qz, n_qx, n_qy, n_qz;
    logic [47:0]      r_sx, r_sy, r_sz, n_sx, n_sy, n_sz;
    logic [D2_W-1:0]  r_d2, n_d2;
    logic [62:0]      r_w, n_w;
    logic [63:0]      r_p0, r_p1, n_p0, n_p1;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [31:0]      r_res, n_res;
    logic             r_res_hit, n_res_hit, r_res_none, n_res_none;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_value, n_value;
    logic             r_coinc, n_coinc, r_none, n_none;

    t_div_req         w_req;
    logic             w_div_busy, w_div_done;
    logic [63:0]      w_quot;
    logic             w_wr_en;
    t_entry           w_wr_data;
    t_entry           w_rd;
    logic             w_rd_act;
    logic             w_in_acc;
    logic             w_out_load;
    logic [24:0]      w_dx, w_dy, w_dz;
    logic [23:0]      w_mx, w_my, w_mz;
    logic [31:0]      w_mag;
    logic [95:0]      w_prod;
    logic [NUM_W-1:0] w_term;
    logic [NUM_W-1:0] w_nmag;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign w_wr_en    = w_in_acc && (i_op == OP_WRITE) && (32'(i_index) < MAX_ENTRIES);
    assign w_wr_data  = '{x: i_pos_x, y: i_pos_y, z: i_pos_z, load: i_load_in};

    idi_table #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_index)),
        .i_wr_data (w_wr_data),
        .i_wr_act  (i_active_in),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd),
        .o_rd_act  (w_rd_act)
    );

    idi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_op == OP_QUERY) n_state = S_RD;
            end
            S_RD: begin
                if (r_idx == r_n) begin
                    n_state = r_any ? S_DIVF : S_OUT;
                end else if (w_rd_act) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = (n_d2 < D2_W'(r_hit)) ? S_OUT : S_DIVW;
            S_DIVW: if (w_div_done) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_ACC;
            S_ACC:  n_state = S_RD;
            S_DIVF: if (w_div_done) n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx      = r_idx;
        n_n        = r_n;
        n_any      = r_any;
        n_qx       = r_qx;
        n_qy       = r_qy;
        n_qz       = r_qz;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_sz       = r_sz;
        n_d2       = r_d2;
        n_w        = r_w;
        n_p0       = r_p0;
        n_p1       = r_p1;
        n_num      = r_num;
        n_den      = r_den;
        n_res      = r_res;
        n_res_hit  = r_res_hit;
        n_res_none = r_res_none;
        n_out_valid = r_out_valid && i_out_stall;
        n_value    = r_value;
        n_coinc    = r_coinc;
        n_none     = r_none;
        w_req      = '{start: 1'b0, numer: '0, denom: '0, iters: W_ITERS};

        w_dx  = {w_rd.x[23], w_rd.x} - {r_qx[23], r_qx};
        w_dy  = {w_rd.y[23], w_rd.y} - {r_qy[23], r_qy};
        w_dz  = {w_rd.z[23], w_rd.z} - {r_qz[23], r_qz};
        w_mx  = w_dx[24] ? 24'(-w_dx) : w_dx[23:0];
        w_my  = w_dy[24] ? 24'(-w_dy) : w_dy[23:0];
        w_mz  = w_dz[24] ? 24'(-w_dz) : w_dz[23:0];
        w_mag = w_rd.load[31] ? (32'd0 - w_rd.load) : w_rd.load;
        w_prod = {r_p1, 32'd0} + {32'd0, r_p0};
        w_term = w_rd.load[31] ? (NUM_W'(0) - {32'd0, w_prod}) : {32'd0, w_prod};
        w_nmag = r_num[NUM_W-1] ? (NUM_W'(0) - r_num) : r_num;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_op == OP_QUERY) begin
                    n_idx = '0;
                    n_n   = (32'(r_entries) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(r_entries);
                    n_any = 1'b0;
                    n_qx  = i_pos_x;
                    n_qy  = i_pos_y;
                    n_qz  = i_pos_z;
                    n_num = '0;
                    n_den = '0;
                end
            end
            S_RD: begin
                if (r_idx == r_n) begin
                    if (r_any) begin
                        w_req = '{start: 1'b1, numer: w_nmag, denom: r_den, iters: F_ITERS};
                    end else begin
                        n_res      = '0;
                        n_res_hit  = 1'b0;
                        n_res_none = 1'b1;
                    end
                end else if (w_rd_act) begin
                    n_any = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SQ: begin
                n_sx = w_mx * w_mx;
                n_sy = w_my * w_my;
                n_sz = w_mz * w_mz;
            end
            S_SUM: begin
                n_d2 = D2_W'(r_sx) + D2_W'(r_sy) + D2_W'(r_sz);
            end
            S_DIVW: begin
                if (w_div_done) n_w = w_quot[62:0];
            end
            S_MUL0: n_p0 = r_w[31:0] * w_mag;
            S_MUL1: n_p1 = 64'(r_w[62:32] * w_mag);
            S_ACC: begin
                n_num = r_num + w_term;
                n_den = r_den + DEN_W'(r_w);
                n_idx = r_idx + 1'b1;
            end
            S_DIVF: begin
                if (w_div_done) begin
                    n_res      = r_num[NUM_W-1] ? (32'd0 - w_quot[31:0]) : w_quot[31:0];
                    n_res_hit  = 1'b0;
                    n_res_none = 1'b0;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_value     = r_res;
                    n_coinc     = r_res_hit;
                    n_none      = r_res_none;
                end
            end
            default: ;
        endcase

        if (r_state == S_SUM) begin
            if (n_d2 < D2_W'(r_hit)) begin
                n_res      = w_rd.load;
                n_res_hit  = 1'b1;
                n_res_none = 1'b0;
            end else begin
                w_req = '{start: 1'b1, numer: {1'b1, {(NUM_W-1){1'b0}}},
                          denom: (n_d2 == '0) ? DEN_W'(1) : DEN_W'(n_d2),
                          iters: W_ITERS};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_hit       <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ENTRIES: r_entries <= i_cfg_data[6:0];
                    CFG_HIT:     r_hit     <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_any      <= n_any;
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_qz       <= n_qz;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_sz       <= n_sz;
        r_d2       <= n_d2;
        r_w        <= n_w;
        r_p0       <= n_p0;
        r_p1       <= n_p1;
        r_num      <= n_num;
        r_den      <= n_den;
        r_res      <= n_res;
        r_res_hit  <= n_res_hit;
        r_res_none <= n_res_none;
        r_value    <= n_value;
        r_coinc    <= n_coinc;
        r_none     <= n_none;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_coincident  = r_coinc;
    assign o_none_active = r_none;

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_busy) else $error("divider busy while idle");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_coinc && r_none)) else $error("hit and none together");
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_idx <= r_n)) else $error("walk past end");
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_IDLE)) else $error("write outside idle");

endmodule
